>>> src/decimal_count_rle_decoder_unit_defines.svh
// Assertion macros shared by the decoder RTL
`ifndef DECIMAL_COUNT_RLE_DECODER_UNIT_DEFINES_SVH
`define DECIMAL_COUNT_RLE_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DCRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DCRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DCRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define DCRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/dcrle_pkg.sv
// Types and constants of the decimal-count run-length decoder
`timescale 1ns / 1ps

package dcrle_pkg;

    localparam int COUNT_BITS = 16;
    localparam int RUN_W      = 16;
    localparam int CNT_W      = (COUNT_BITS > RUN_W) ? RUN_W : COUNT_BITS;
    localparam logic [RUN_W-1:0] CNT_MAX = RUN_W'((33'd1 << CNT_W) - 33'd1);

    localparam logic [7:0] BSLASH    = 8'h5C;
    localparam logic [7:0] ALIAS_RST = 8'hE0;
    localparam logic [7:0] DIGIT_0   = 8'd48;
    localparam logic [7:0] DIGIT_9   = 8'd57;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [RUN_W-1:0] run_length;
        logic             count_saturated;
        logic             last_of_item;
    } out_t;

    typedef struct packed {
        logic             escape_pending;
        logic             counting;
        logic [RUN_W-1:0] run_count;
        logic             overflowed;
    } dec_state_t;

    // results of one input word: up to two
    typedef struct packed {
        logic [1:0] num;
        out_t       r0;
        out_t       r1;
    } step_res_t;

endpackage

>>> src/dcrle_step.sv
// Per-word decode: next state and up to two result words
`timescale 1ns / 1ps

module dcrle_step (
    input  dcrle_pkg::dec_state_t st,
    input  dcrle_pkg::in_t        item,
    input  logic [7:0]            alias_byte,
    output dcrle_pkg::dec_state_t st_next,
    output dcrle_pkg::step_res_t  res
);
    import dcrle_pkg::*;

    logic             is_dig;
    logic [3:0]       digit;
    logic [7:0]       mapped;
    logic [RUN_W+3:0] acc;

    assign is_dig = (item.in_byte >= DIGIT_0) && (item.in_byte <= DIGIT_9);
    assign digit  = 4'(item.in_byte - DIGIT_0);
    assign mapped = (item.in_byte == alias_byte) ? BSLASH : item.in_byte;
    // count*10 + digit as shift-and-add
    assign acc = {1'b0, st.run_count, 3'b000} + {3'b000, st.run_count, 1'b0}
               + {{RUN_W{1'b0}}, digit};

    always_comb
    begin
        logic normal;
        out_t e;
        normal  = 1'b1;
        st_next = st;
        res     = '0;
        e       = '0;

        if (st.escape_pending)
        begin
            st_next.escape_pending = 1'b0;
            e.run_length = RUN_W'(1);
            if (is_dig)
            begin
                e.out_byte = item.in_byte;
                normal = 1'b0;
            end
            else
            begin
                e.out_byte = BSLASH;
            end
            res.r0  = e;
            res.num = 2'd1;
        end

        if (normal)
        begin
            if (st.counting)
            begin
                if (is_dig)
                begin
                    if (acc > {4'b0000, CNT_MAX})
                    begin
                        st_next.run_count  = CNT_MAX;
                        st_next.overflowed = 1'b1;
                    end
                    else
                    begin
                        st_next.run_count = acc[RUN_W-1:0];
                    end
                end
                else
                begin
                    if (st.run_count != '0)
                    begin
                        e.out_byte        = mapped;
                        e.run_length      = st.run_count;
                        e.count_saturated = st.overflowed;
                        e.last_of_item    = 1'b0;
                        if (res.num == 2'd0)
                            res.r0 = e;
                        else
                            res.r1 = e;
                        res.num = res.num + 2'd1;
                    end
                    st_next.counting   = 1'b0;
                    st_next.run_count  = '0;
                    st_next.overflowed = 1'b0;
                end
            end
            else if (is_dig)
            begin
                st_next.counting = 1'b1;
                if ({{(RUN_W-4){1'b0}}, digit} > CNT_MAX)
                begin
                    st_next.run_count  = CNT_MAX;
                    st_next.overflowed = 1'b1;
                end
                else
                begin
                    st_next.run_count  = {{(RUN_W-4){1'b0}}, digit};
                    st_next.overflowed = 1'b0;
                end
            end
            else if (item.in_byte == BSLASH)
            begin
                st_next.escape_pending = 1'b1;
            end
            else
            begin
                e.out_byte        = mapped;
                e.run_length      = RUN_W'(1);
                e.count_saturated = 1'b0;
                e.last_of_item    = 1'b0;
                if (res.num == 2'd0)
                    res.r0 = e;
                else
                    res.r1 = e;
                res.num = res.num + 2'd1;
            end
        end

        if (item.stream_end)
        begin
            // flush a dangling escape, drop partial count
            if (st_next.escape_pending)
            begin
                e.out_byte        = BSLASH;
                e.run_length      = RUN_W'(1);
                e.count_saturated = 1'b0;
                e.last_of_item    = 1'b0;
                if (res.num == 2'd0)
                    res.r0 = e;
                else
                    res.r1 = e;
                res.num = res.num + 2'd1;
            end
            st_next = '0;
        end

        if (res.num == 2'd1)
            res.r0.last_of_item = 1'b1;
        else if (res.num == 2'd2)
            res.r1.last_of_item = 1'b1;
    end

endmodule

>>> src/dcrle_fifo.sv
// Four-word result queue, takes up to two words per cycle
`timescale 1ns / 1ps

module dcrle_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_num,
    input  dcrle_pkg::out_t    push0,
    input  dcrle_pkg::out_t    push1,
    input  logic               pop,
    output logic               room2,
    output logic               not_empty,
    output dcrle_pkg::out_t    head
);
    import dcrle_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    out_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;

    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);
    assign room2     = count_reg <= (PTR_W+1)'(DEPTH - 2);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_num);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push_num) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_num != 2'd0)
            mem_reg[wr_ptr_reg] <= push0;
        if (push_num == 2'd2)
            mem_reg[wr_ptr_p1] <= push1;
    end

endmodule

>>> src/decimal_count_rle_decoder_unit.sv
// Decimal-count run-length decoder, top level
`timescale 1ns / 1ps

// Takes one compressed byte per cycle. A byte is registered on entry, decoded
// in the next cycle against the escape/count state, and its results (none, one
// or two) are written into a four-word output queue, which drives the output.
// Bytes that yield at most one result run at one per cycle while the queue has
// room; a byte that yields two (a failed escape followed by a literal, or by a
// new escape flushed at stream end) puts two words into the queue, which the
// output port then delivers one word per cycle while out_stall is low. Input
// stalls only while the queue holds more than two words. backslash_alias may
// be written only while the decoder is idle.

module decimal_count_rle_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dcrle_pkg::in_t     in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output dcrle_pkg::out_t    out_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata
);
    import dcrle_pkg::*;
    `include "decimal_count_rle_decoder_unit_defines.svh"

    logic       stage_valid_reg;
    in_t        stage_data_reg;
    dec_state_t state_reg, state_next;
    logic [7:0] alias_reg;
    step_res_t  res;
    logic       room2;
    logic       advance;
    logic       in_take;
    logic       out_take;

    assign advance  = stage_valid_reg && room2;
    assign in_stall = stage_valid_reg && !room2;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    dcrle_step u_step (
        .st         (state_reg),
        .item       (stage_data_reg),
        .alias_byte (alias_reg),
        .st_next    (state_next),
        .res        (res)
    );

    dcrle_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_num  (advance ? res.num : 2'd0),
        .push0     (res.r0),
        .push1     (res.r1),
        .pop       (out_take),
        .room2     (room2),
        .not_empty (out_valid),
        .head      (out_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            state_reg       <= '0;
            alias_reg       <= ALIAS_RST;
        end
        else
        begin
            if (in_take)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            if (cfg_we)
                alias_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            stage_data_reg <= in_data;
    end

    `DCRLE_ASSERT_IMP(a_stall_needs_backlog, clk, rst_n, in_stall, out_valid, "stall with empty queue")
    `DCRLE_ASSERT_IMP(a_escape_not_counting, clk, rst_n, state_reg.escape_pending, !state_reg.counting, "escape during count")
    `DCRLE_ASSERT_IMP(a_idle_count_clear, clk, rst_n, !state_reg.counting, (state_reg.run_count == '0) && !state_reg.overflowed, "count state left over")
    `DCRLE_ASSERT_NXT(a_end_clears_state, clk, rst_n, advance && stage_data_reg.stream_end, state_reg == '0, "state not cleared at stream end")

endmodule
